// ----- rtl/b64sc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, status codes and alphabet functions for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GROUP_W  = 24;
  localparam int unsigned NUM_OUT  = 4;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEN = 2'd2;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3d;

  localparam logic [0:0] REG_DECODE_MODE = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                out_last;
    logic [STATUS_W-1:0] status;
  } word_t;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] sextet;
  } code_t;

  function automatic logic [BYTE_W-1:0] enc_char(logic [5:0] idx);
    logic [BYTE_W-1:0] v;
    v = {2'b00, idx};
    if (idx < 6'd26) begin
      enc_char = 8'(8'h41 + v);
    end else if (idx < 6'd52) begin
      enc_char = 8'(8'h61 + v - 8'd26);
    end else if (idx < 6'd62) begin
      enc_char = 8'(8'h30 + v - 8'd52);
    end else if (idx == 6'd62) begin
      enc_char = 8'h2b;
    end else begin
      enc_char = 8'h2f;
    end
  endfunction

  function automatic code_t char_code(logic [BYTE_W-1:0] c);
    code_t r;
    r.bad    = 1'b0;
    r.pad    = 1'b0;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.sextet = 6'd62;
    end else if (c == 8'h2f) begin
      r.sextet = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/b64sc_if.sv -----
// ----------------------------------------------------------------------------
// b64sc_if
// Valid/ready stream channels for the Base64 codec input and output words.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  import b64sc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_out_if;
  import b64sc_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output out_byte, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

// ----- rtl/base64_stream_codec_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Base64 (standard alphabet) encoder/decoder on a byte stream, APB mode reg.
// ----------------------------------------------------------------------------
// Input words are registered; their results are registered in the output buffer.
// Throughput: one input word per cycle while the output buffer keeps up;
//   output is one word per cycle while the sink is ready; encode: 4 words per 3 bytes.
// A completed group loads up to 4 result words into an output buffer.
// Reset (rst, synchronous): encode mode, empty group, no pending words.
module base64_stream_codec_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [b64sc_pkg::APB_AW-1:0] paddr,
  input  logic [b64sc_pkg::APB_DW-1:0] pwdata,
  output logic [b64sc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  b64sc_in_if.sink                    din,
  b64sc_out_if.source                 dout
);
  import b64sc_pkg::*;

  logic                decode_mode;
  logic [GROUP_W-1:0]  group_bits;
  logic [1:0]          group_count;
  logic                group_bad;
  logic [1:0]          pad_count;

  logic                ir_valid;
  logic [BYTE_W-1:0]   ir_byte;
  logic                ir_last;

  word_t               ob [NUM_OUT];
  logic [2:0]          ob_cnt;
  logic [1:0]          ob_idx;

  logic [GROUP_W-1:0]  group_bits_next;
  logic [1:0]          group_count_next;
  logic                group_bad_next;
  logic [1:0]          pad_count_next;
  word_t               res [NUM_OUT];
  logic [2:0]          res_cnt;

  logic                cfg_wr;
  logic                buf_free;
  logic                fire;
  logic                pop;

  assign pready = 1'b1;
  assign prdata = {{(APB_DW-1){1'b0}}, decode_mode};
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_DECODE_MODE);

  assign pop      = dout.valid && dout.ready;
  assign buf_free = (ob_cnt == 3'd0) || (ob_cnt == 3'd1 && dout.ready);
  assign fire     = ir_valid && ((res_cnt == 3'd0) || buf_free);
  assign din.ready = !ir_valid || fire;

  assign dout.valid    = ob_cnt != 3'd0;
  assign dout.out_byte = ob[ob_idx].out_byte;
  assign dout.out_last = ob[ob_idx].out_last;
  assign dout.status   = ob[ob_idx].status;

  // group update and result words for the word in the input register
  always_comb begin
    logic [GROUP_W-1:0] eb;
    logic [GROUP_W-1:0] sh;
    logic [1:0]         n;
    code_t              cc;
    logic               bad;
    logic [1:0]         pc;
    logic [1:0]         nbytes;
    eb     = {group_bits[15:0], ir_byte};
    sh     = eb;
    n      = 2'(group_count + 2'd1);
    cc     = char_code(ir_byte);
    bad    = group_bad;
    pc     = pad_count;
    nbytes = 2'd0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    group_bad_next   = group_bad;
    pad_count_next   = pad_count;
    res_cnt          = 3'd0;
    for (int k = 0; k < NUM_OUT; k++) begin
      res[k] = '{out_byte: '0, out_last: 1'b0, status: ST_OK};
    end
    if (!decode_mode) begin
      if (group_count != 2'd2 && !ir_last) begin
        group_bits_next  = eb;
        group_count_next = n;
      end else begin
        case (group_count)
          2'd0:    sh = {eb[7:0], 16'd0};
          2'd1:    sh = {eb[15:0], 8'd0};
          default: sh = eb;
        endcase
        for (int k = 0; k < NUM_OUT; k++) begin
          if (k > int'(group_count) + 1) begin
            res[k].out_byte = PAD_CHAR;
          end else begin
            res[k].out_byte = enc_char(sh[GROUP_W-1-6*k -: 6]);
          end
        end
        res[NUM_OUT-1].out_last = ir_last;
        res_cnt          = 3'd4;
        group_bits_next  = '0;
        group_count_next = 2'd0;
        group_bad_next   = 1'b0;
        pad_count_next   = 2'd0;
      end
    end else begin
      if (cc.bad) begin
        bad = 1'b1;
      end else if (cc.pad) begin
        if (group_count < 2'd2) bad = 1'b1;
        else pc = 2'(pad_count + 2'd1);
      end else if (pad_count != 2'd0) begin
        bad = 1'b1;
      end
      eb = {group_bits[17:0], (cc.bad || cc.pad) ? 6'd0 : cc.sextet};
      if (group_count != 2'd3) begin
        if (ir_last) begin
          res[0]           = '{out_byte: '0, out_last: 1'b1, status: ST_LEN};
          res_cnt          = 3'd1;
          group_bits_next  = '0;
          group_count_next = 2'd0;
          group_bad_next   = 1'b0;
          pad_count_next   = 2'd0;
        end else begin
          group_bits_next  = eb;
          group_count_next = n;
          group_bad_next   = bad;
          pad_count_next   = pc;
        end
      end else begin
        group_bits_next  = '0;
        group_count_next = 2'd0;
        group_bad_next   = 1'b0;
        pad_count_next   = 2'd0;
        if (bad || (pc != 2'd0 && !ir_last) || pc == 2'd3) begin
          res[0]  = '{out_byte: '0, out_last: ir_last, status: ST_BAD};
          res_cnt = 3'd1;
        end else begin
          nbytes = 2'(2'd3 - pc);
          for (int k = 0; k < 3; k++) begin
            res[k].out_byte = eb[GROUP_W-1-8*k -: 8];
            res[k].out_last = (k + 1 == int'(nbytes)) ? ir_last : 1'b0;
          end
          res_cnt = {1'b0, nbytes};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= '0;
      group_count <= 2'd0;
      group_bad   <= 1'b0;
      pad_count   <= 2'd0;
      ir_valid    <= 1'b0;
      ob_cnt      <= 3'd0;
      ob_idx      <= 2'd0;
    end else begin
      if (cfg_wr) begin
        decode_mode <= pwdata[0];
        group_bits  <= '0;
        group_count <= 2'd0;
        group_bad   <= 1'b0;
        pad_count   <= 2'd0;
      end else if (fire) begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        group_bad   <= group_bad_next;
        pad_count   <= pad_count_next;
      end
      if (din.valid && din.ready) begin
        ir_valid <= 1'b1;
      end else if (fire) begin
        ir_valid <= 1'b0;
      end
      if (fire && res_cnt != 3'd0) begin
        ob_cnt <= res_cnt;
        ob_idx <= 2'd0;
      end else if (pop) begin
        ob_cnt <= 3'(ob_cnt - 3'd1);
        ob_idx <= 2'(ob_idx + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      ir_byte <= din.in_byte;
      ir_last <= din.in_last;
    end
    if (fire && res_cnt != 3'd0) begin
      for (int k = 0; k < NUM_OUT; k++) begin
        ob[k] <= res[k];
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Base64 stream codec in both modes against a cycle-free model of
// the group logic. Byte messages and text messages (well formed, corrupted,
// truncated and random noise) are streamed with random source and sink
// stalls. Every output word is compared in order with the predicted word.
// ----------------------------------------------------------------------------
module testbench;
  import b64sc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 36;
  localparam int PAD_IDX       = 64;
  localparam int NO_CODE       = -1;
  localparam logic [APB_AW-1:0] MODE_ADDR = APB_AW'(4 * REG_DECODE_MODE);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } in_word_t;

  typedef enum int {
    FLIP_ANY, PAD_ANYWHERE, CUT_SHORT, PAD_EARLY_GROUP, HIGH_BYTE
  } flaw_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  b64sc_in_if  din_ch ();
  b64sc_out_if dout_ch ();

  base64_stream_codec_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din     (din_ch),
    .dout    (dout_ch)
  );

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  // model state
  logic                dec_mode;
  logic [GROUP_W-1:0]  grp_bits;
  logic [1:0]          grp_cnt;
  logic                grp_bad;
  logic [1:0]          pad_cnt;

  in_word_t          stim_q[$];
  word_t             due_words[$];
  logic [BYTE_W-1:0] msg[$];

  word_t seen_word;
  word_t due_word;
  in_word_t next_in;

  int src_gap;
  int snk_gap;
  int src_pct;
  int snk_pct;
  bit calm;
  int cycles;
  int mismatches;
  int bytes_queued;
  int bytes_taken;
  int words_checked;
  int mode_writes;
  int pct_menu[4] = '{0, 2, 6, 15};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    grp_bad  = 1'b0;
    pad_cnt  = '0;
  endtask

  task automatic push_word(input logic [BYTE_W-1:0] b, input logic last,
                           input logic [STATUS_W-1:0] st);
    word_t w;
    w.out_byte = b;
    w.out_last = last;
    w.status   = st;
    due_words.push_back(w);
  endtask

  function automatic int code_of(input logic [BYTE_W-1:0] c);
    for (int i = 0; i <= PAD_IDX; i++) begin
      if (b64_alphabet[i] == c) return i;
    end
    return NO_CODE;
  endfunction

  task automatic predict_codec(input logic [BYTE_W-1:0] b, input logic last);
    int n;
    int p;
    int v;
    int idx;
    int nbytes;
    logic [GROUP_W-1:0] bits;
    logic [5:0] sextet;
    if (!dec_mode) begin
      n = grp_cnt + 1;
      grp_bits = {grp_bits[15:0], b};
      if (n < 3 && !last) begin
        grp_cnt = 2'(n);
      end else begin
        bits = grp_bits << (8 * (3 - n));
        for (int k = 0; k < 4; k++) begin
          idx = int'((bits >> (18 - 6 * k)) & 24'h3f);
          if (k > n) idx = PAD_IDX;
          push_word(b64_alphabet[idx], (k == 3) ? last : 1'b0, ST_OK);
        end
        clear_group();
      end
    end else begin
      p = grp_cnt;
      v = code_of(b);
      sextet = '0;
      if (v == NO_CODE) begin
        grp_bad = 1'b1;
      end else if (v == PAD_IDX) begin
        if (p < 2) grp_bad = 1'b1;
        else pad_cnt = pad_cnt + 2'd1;
      end else begin
        if (pad_cnt != 0) grp_bad = 1'b1;
        sextet = 6'(v);
      end
      grp_bits = {grp_bits[17:0], sextet};
      if (p < 3) begin
        if (last) begin
          push_word(8'h00, 1'b1, ST_LEN);
          clear_group();
        end else begin
          grp_cnt = 2'(p + 1);
        end
      end else if (grp_bad || (pad_cnt != 0 && !last) || pad_cnt > 2) begin
        push_word(8'h00, last, ST_BAD);
        clear_group();
      end else begin
        nbytes = 3 - pad_cnt;
        for (int k = 0; k < nbytes; k++) begin
          push_word(8'(grp_bits >> (16 - 8 * k)), (k + 1 == nbytes) ? last : 1'b0, ST_OK);
        end
        clear_group();
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      din_ch.valid <= 1'b0;
      src_gap      <= 0;
    end else if (!din_ch.valid || din_ch.ready) begin
      if (src_gap > 0) begin
        din_ch.valid <= 1'b0;
        src_gap      <= src_gap - 1;
      end else if (!calm && $urandom_range(0, 99) < src_pct) begin
        din_ch.valid <= 1'b0;
        src_gap      <= $urandom_range(0, 16);
      end else if (stim_q.size() > 0) begin
        next_in = stim_q.pop_front();
        din_ch.valid   <= 1'b1;
        din_ch.in_byte <= next_in.data;
        din_ch.in_last <= next_in.last;
      end else begin
        din_ch.valid <= 1'b0;
      end
    end
  end

  // output sink
  always @(posedge clk) begin
    if (rst) begin
      dout_ch.ready <= 1'b0;
      snk_gap       <= 0;
    end else if (snk_gap > 0) begin
      dout_ch.ready <= 1'b0;
      snk_gap       <= snk_gap - 1;
    end else if (!calm && $urandom_range(0, 99) < snk_pct) begin
      dout_ch.ready <= 1'b0;
      snk_gap       <= $urandom_range(0, 16);
    end else begin
      dout_ch.ready <= 1'b1;
    end
  end

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    if (!rst) begin
      if (din_ch.valid && din_ch.ready) begin
        predict_codec(din_ch.in_byte, din_ch.in_last);
        bytes_taken++;
      end
      if (dout_ch.valid && dout_ch.ready) begin
        seen_word.out_byte = dout_ch.out_byte;
        seen_word.out_last = dout_ch.out_last;
        seen_word.status   = dout_ch.status;
        if (due_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, got byte %h last %0d status %0d",
                   $time, seen_word.out_byte, seen_word.out_last, seen_word.status);
        end else begin
          due_word = due_words.pop_front();
          words_checked++;
          if (seen_word.out_byte !== due_word.out_byte ||
              seen_word.out_last !== due_word.out_last ||
              seen_word.status !== due_word.status) begin
            mismatches++;
            $display({"%0t: mismatch, expected byte %h last %0d status %0d, ",
                      "got byte %h last %0d status %0d"},
                     $time, due_word.out_byte, due_word.out_last, due_word.status,
                     seen_word.out_byte, seen_word.out_last, seen_word.status);
          end
        end
      end
    end
  end

  task automatic send_msg(input bit terminate);
    in_word_t w;
    for (int i = 0; i < msg.size(); i++) begin
      w.data = msg[i];
      w.last = terminate && (i == msg.size() - 1);
      stim_q.push_back(w);
    end
    bytes_queued += msg.size();
    msg.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic build_text(input int ngroups, input int npad);
    for (int g = 0; g < ngroups; g++) begin
      for (int c = 0; c < 4; c++) begin
        if (g == ngroups - 1 && c >= 4 - npad) msg.push_back(PAD_CHAR);
        else msg.push_back(b64_alphabet[$urandom_range(0, 63)]);
      end
    end
  endtask

  task automatic break_text(input flaw_t flaw);
    int pos;
    pos = $urandom_range(0, msg.size() - 1);
    case (flaw)
      FLIP_ANY:     msg[pos] = 8'($urandom_range(0, 255));
      PAD_ANYWHERE: msg[pos] = PAD_CHAR;
      CUT_SHORT: begin
        repeat ($urandom_range(1, 3)) void'(msg.pop_back());
      end
      PAD_EARLY_GROUP: begin
        msg[3] = PAD_CHAR;
        if ($urandom_range(0, 1)) msg[2] = PAD_CHAR;
      end
      default:      msg[pos] = 8'($urandom_range(128, 255));
    endcase
  endtask

  task automatic drain();
    wait (stim_q.size() == 0 && din_ch.valid === 1'b0);
    wait (due_words.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    dec_mode = value;
    clear_group();
    mode_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DW'(value)) begin
      mismatches++;
      $display("%0t: mode readback, expected %h, got %h", $time, APB_DW'(value), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic encode_phase(input int target);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 7))
        msg.push_back(8'($urandom_range(0, 255)));
      send_msg(1'b1);
    end
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 2)) msg.push_back(8'($urandom_range(0, 255)));
      send_msg(1'b0);
    end
  endtask

  task automatic decode_phase(input int target);
    int start;
    int ngroups;
    int roll;
    flaw_t flaw;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      ngroups = $urandom_range(1, 4);
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        build_text(ngroups, $urandom_range(0, 2));
      end else if (roll < 93) begin
        flaw = flaw_t'($urandom_range(FLIP_ANY, HIGH_BYTE));
        if (flaw == PAD_EARLY_GROUP && ngroups < 2) ngroups = 2;
        build_text(ngroups, $urandom_range(0, 2));
        break_text(flaw);
      end else begin
        repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(0, 255)));
      end
      send_msg(1'b1);
    end
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 3)) msg.push_back(b64_alphabet[$urandom_range(0, 64)]);
      send_msg(1'b0);
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    din_ch.valid   = 1'b0;
    din_ch.in_byte = '0;
    din_ch.in_last = 1'b0;
    dout_ch.ready  = 1'b0;
    cycles         = 0;
    mismatches     = 0;
    bytes_queued   = 0;
    bytes_taken    = 0;
    words_checked  = 0;
    mode_writes    = 0;
    calm           = 1'b0;
    src_pct        = 5;
    snk_pct        = 5;
    dec_mode       = 1'b0;
    clear_group();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // encode: one and two byte flushes, full group, partial group dropped by mode write
    msg.push_back(8'hff);
    send_msg(1'b1);
    msg.push_back(8'h00);
    msg.push_back(8'hff);
    send_msg(1'b1);
    msg.push_back(8'hff);
    msg.push_back(8'h00);
    msg.push_back(8'h80);
    send_msg(1'b1);
    msg.push_back(8'h5a);
    send_msg(1'b0);
    drain();
    write_mode(1'b0);

    // decode: alphabet extremes, pad too early, data after pad,
    // padded group mid message, short message holding a high byte
    write_mode(1'b1);
    add_text("A/+9");
    send_msg(1'b0);
    add_text("Q=AA");
    send_msg(1'b0);
    add_text("QQ=A");
    send_msg(1'b0);
    add_text("QQ==");
    send_msg(1'b0);
    msg.push_back("Q");
    msg.push_back(8'h80);
    send_msg(1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm    = (ph == PHASES - 1);
      src_pct = pct_menu[$urandom_range(0, 3)];
      snk_pct = pct_menu[$urandom_range(0, 3)];
      write_mode(ph % 2 == 1);
      if (ph % 2 == 0) encode_phase(PHASE_BYTES);
      else decode_phase(PHASE_BYTES);
      drain();
    end

    $display("run: %0d input bytes over both modes, %0d output words checked, %0d mode writes",
             bytes_taken, words_checked, mode_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/b64sc_pkg.sv
rtl/b64sc_if.sv
rtl/base64_stream_codec_top.sv
bench/testbench.sv
